// ===== src/rchd_pkg.sv =====
// ----------------------------------------------------------------------------
// rchd_pkg - ray/circle hit distance: types and widths
// Word layouts and the derived widths of every pipeline quantity.
// ----------------------------------------------------------------------------
package rchd_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;

    // f = origin - center
    localparam int FW  = COORD_BITS + 1;
    // products of f and d, signed
    localparam int FDW = 2 * COORD_BITS + 2;
    // radius squared
    localparam int RW  = 2 * COORD_BITS - 2;
    // a = |d|^2, unsigned
    localparam int AW  = 2 * COORD_BITS;
    // h signed and its magnitude
    localparam int HSW = 2 * COORD_BITS + 2;
    localparam int HM  = 2 * COORD_BITS + 1;
    // c signed and its magnitude
    localparam int CSW = 2 * COORD_BITS + 3;
    localparam int CM  = 2 * COORD_BITS + 2;
    // discriminant and the scaled radicand
    localparam int DW  = 4 * COORD_BITS + 3;
    localparam int EW  = DW + 2 * FRAC_BITS;
    localparam int SW  = (EW + 1) / 2;
    localparam int EE  = 2 * SW;
    localparam int TW  = SW + 3;
    localparam int RMW = SW + 1;
    // numerator of the root
    localparam int MW  = HM + FRAC_BITS;
    localparam int NW  = ((MW > SW) ? MW : SW) + 1;
    // divider remainder
    localparam int QW  = AW + COORD_BITS;

    // operand splits for the wide squares and products
    localparam int HL  = (HM + 1) / 2;
    localparam int HH  = HM - HL;
    localparam int AL  = AW / 2;
    localparam int AH  = AW - AL;
    localparam int CL  = (CM + 1) / 2;
    localparam int CH  = CM - CL;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic        [COORD_BITS-2:0] radius;
    } rchd_query_t;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] distance;
        logic                  saturated;
    } rchd_result_t;

    // quantities that ride alongside the square root
    typedef struct packed {
        logic [HM-1:0] hmag;
        logic          hn;
        logic          cn;
        logic          czero;
        logic [AW-1:0] a;
        logic          nohit;
    } rchd_side_t;

endpackage

// ===== src/ray_circle_hit_distance_core.sv =====
// ----------------------------------------------------------------------------
// ray_circle_hit_distance_core - 2D ray against circle, distance to first hit
// Fully pipelined; one query word per cycle.
// ----------------------------------------------------------------------------
// Use: drive a query word and raise start for one cycle; it is taken at that
// edge (busy is always low, so a new query may follow every cycle).
// Each query gives exactly one result word. done is high for one cycle with
// the result word on result; the receiver must take it then, it cannot stall.
// done rises once the query word has passed every stage below, from the
// offsets through the divider to the output register.
// Throughput: one word per cycle. The depth is set by the square root unit
// (one root bit per stage, 2*COORD_BITS + FRAC_BITS + 2 stages) and the
// divider (one quotient bit per stage, COORD_BITS stages); h^2 and a*|c|
// go through partial products of at most 25 by 25 bits.
// Reset clears the valid bits of every stage, so words in flight are
// dropped and done stays low until a new query has passed through.
// ----------------------------------------------------------------------------
module ray_circle_hit_distance_core
    import rchd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  rchd_query_t  query,
    output logic         done,
    output rchd_result_t result
);

    localparam int LAT = SW + COORD_BITS + 10;

    assign busy = 1'b0;

    // ---------------- stage 1: offsets
    logic                         s1_valid_reg;
    logic signed [FW-1:0]         s1_fx_reg, s1_fy_reg;
    logic signed [COORD_BITS-1:0] s1_dx_reg, s1_dy_reg;
    logic [COORD_BITS-2:0]        s1_rad_reg;
    logic signed [FW-1:0]         fx_next, fy_next;

    assign fx_next = FW'(query.origin_x) - FW'(query.center_x);
    assign fy_next = FW'(query.origin_y) - FW'(query.center_y);

    // ---------------- stage 2: products
    logic                  s2_valid_reg;
    logic signed [FDW-1:0] s2_dxx_reg, s2_dyy_reg, s2_fxdx_reg, s2_fydy_reg;
    logic signed [FDW-1:0] s2_fxx_reg, s2_fyy_reg;
    logic [RW-1:0]         s2_rr_reg;
    logic signed [FDW-1:0] dxx_next, dyy_next, fxdx_next, fydy_next, fxx_next, fyy_next;
    logic [RW-1:0]         rr_next;

    assign dxx_next  = FDW'(s1_dx_reg) * FDW'(s1_dx_reg);
    assign dyy_next  = FDW'(s1_dy_reg) * FDW'(s1_dy_reg);
    assign fxdx_next = FDW'(s1_fx_reg) * FDW'(s1_dx_reg);
    assign fydy_next = FDW'(s1_fy_reg) * FDW'(s1_dy_reg);
    assign fxx_next  = FDW'(s1_fx_reg) * FDW'(s1_fx_reg);
    assign fyy_next  = FDW'(s1_fy_reg) * FDW'(s1_fy_reg);
    assign rr_next   = RW'(s1_rad_reg) * RW'(s1_rad_reg);

    // ---------------- stage 3: a, h, c
    logic                  s3_valid_reg;
    logic [AW-1:0]         s3_a_reg;
    logic signed [HSW-1:0] s3_h_reg;
    logic signed [CSW-1:0] s3_c_reg;
    logic [AW-1:0]         a_next;
    logic signed [HSW-1:0] h_next;
    logic signed [CSW-1:0] c_next;
    logic signed [FDW-1:0] asum;

    assign asum   = s2_dxx_reg + s2_dyy_reg;
    assign a_next = AW'(asum);
    assign h_next = HSW'(s2_fxdx_reg) + HSW'(s2_fydy_reg);
    assign c_next = CSW'(s2_fxx_reg) + CSW'(s2_fyy_reg) - CSW'(s2_rr_reg);

    // ---------------- stage 4: sign and magnitude
    logic          s4_valid_reg;
    logic [AW-1:0] s4_a_reg;
    logic [HM-1:0] s4_hmag_reg;
    logic [CM-1:0] s4_cmag_reg;
    logic          s4_hn_reg, s4_cn_reg, s4_azero_reg;
    logic signed [HSW-1:0] hneg;
    logic signed [CSW-1:0] cneg;

    assign hneg = -s3_h_reg;
    assign cneg = -s3_c_reg;

    // ---------------- stage 5: partial products of h^2 and a*|c|
    logic                s5_valid_reg;
    logic [2*HL-1:0]     s5_hll_reg;
    logic [HL+HH-1:0]    s5_hlh_reg;
    logic [2*HH-1:0]     s5_hhh_reg;
    logic [AL+CL-1:0]    s5_all_reg;
    logic [AL+CH-1:0]    s5_alh_reg;
    logic [AH+CL-1:0]    s5_ahl_reg;
    logic [AH+CH-1:0]    s5_ahh_reg;
    logic [HM-1:0]       s5_hmag_reg;
    logic [AW-1:0]       s5_a_reg;
    logic                s5_hn_reg, s5_cn_reg, s5_czero_reg, s5_azero_reg;
    logic [HL-1:0]       h_lo;
    logic [HH-1:0]       h_hi;
    logic [AL-1:0]       a_lo;
    logic [AH-1:0]       a_hi;
    logic [CL-1:0]       c_lo;
    logic [CH-1:0]       c_hi;

    assign h_lo = s4_hmag_reg[HL-1:0];
    assign h_hi = s4_hmag_reg[HM-1:HL];
    assign a_lo = s4_a_reg[AL-1:0];
    assign a_hi = s4_a_reg[AW-1:AL];
    assign c_lo = s4_cmag_reg[CL-1:0];
    assign c_hi = s4_cmag_reg[CM-1:CL];

    // ---------------- stage 6: h^2 and a*|c|
    logic          s6_valid_reg;
    logic [DW-1:0] s6_hh_reg, s6_ac_reg;
    logic [HM-1:0] s6_hmag_reg;
    logic [AW-1:0] s6_a_reg;
    logic          s6_hn_reg, s6_cn_reg, s6_czero_reg, s6_azero_reg;
    logic [DW-1:0] hh_next, ac_next;

    assign hh_next = DW'(s5_hll_reg) + (DW'(s5_hlh_reg) << (HL + 1))
                   + (DW'(s5_hhh_reg) << (2 * HL));
    assign ac_next = DW'(s5_all_reg) + (DW'(s5_ahl_reg) << AL)
                   + (DW'(s5_alh_reg) << CL) + (DW'(s5_ahh_reg) << (AL + CL));

    // ---------------- stage 7: quarter discriminant, into the root unit
    logic          sq_valid_reg [0:SW];
    logic [EE-1:0] sq_e_reg     [0:SW];
    logic [SW-1:0] sq_root_reg  [0:SW];
    logic [SW:0]   sq_rem_reg   [0:SW];
    rchd_side_t    sq_side_reg  [0:SW];
    logic [DW-1:0] d_next;
    logic          nodisc;
    rchd_side_t    side_next;

    assign nodisc = !s6_cn_reg && (s6_hh_reg < s6_ac_reg);
    assign d_next = s6_cn_reg ? s6_hh_reg + s6_ac_reg : s6_hh_reg - s6_ac_reg;

    always_comb
    begin
        side_next.hmag  = s6_hmag_reg;
        side_next.hn    = s6_hn_reg;
        side_next.cn    = s6_cn_reg;
        side_next.czero = s6_czero_reg;
        side_next.a     = s6_a_reg;
        side_next.nohit = s6_azero_reg | nodisc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            s6_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= start && !busy;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            sq_valid_reg[0] <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fx_reg   <= fx_next;
        s1_fy_reg   <= fy_next;
        s1_dx_reg   <= query.dir_x;
        s1_dy_reg   <= query.dir_y;
        s1_rad_reg  <= query.radius;

        s2_dxx_reg  <= dxx_next;
        s2_dyy_reg  <= dyy_next;
        s2_fxdx_reg <= fxdx_next;
        s2_fydy_reg <= fydy_next;
        s2_fxx_reg  <= fxx_next;
        s2_fyy_reg  <= fyy_next;
        s2_rr_reg   <= rr_next;

        s3_a_reg    <= a_next;
        s3_h_reg    <= h_next;
        s3_c_reg    <= c_next;

        s4_a_reg     <= s3_a_reg;
        s4_hn_reg    <= s3_h_reg[HSW-1];
        s4_hmag_reg  <= s3_h_reg[HSW-1] ? HM'(hneg) : HM'(s3_h_reg);
        s4_cn_reg    <= s3_c_reg[CSW-1];
        s4_cmag_reg  <= s3_c_reg[CSW-1] ? CM'(cneg) : CM'(s3_c_reg);
        s4_azero_reg <= (s3_a_reg == '0);

        s5_hll_reg   <= (2 * HL)'(h_lo) * (2 * HL)'(h_lo);
        s5_hlh_reg   <= (HL + HH)'(h_lo) * (HL + HH)'(h_hi);
        s5_hhh_reg   <= (2 * HH)'(h_hi) * (2 * HH)'(h_hi);
        s5_all_reg   <= (AL + CL)'(a_lo) * (AL + CL)'(c_lo);
        s5_alh_reg   <= (AL + CH)'(a_lo) * (AL + CH)'(c_hi);
        s5_ahl_reg   <= (AH + CL)'(a_hi) * (AH + CL)'(c_lo);
        s5_ahh_reg   <= (AH + CH)'(a_hi) * (AH + CH)'(c_hi);
        s5_hmag_reg  <= s4_hmag_reg;
        s5_a_reg     <= s4_a_reg;
        s5_hn_reg    <= s4_hn_reg;
        s5_cn_reg    <= s4_cn_reg;
        s5_czero_reg <= (s4_cmag_reg == '0);
        s5_azero_reg <= s4_azero_reg;

        s6_hh_reg    <= hh_next;
        s6_ac_reg    <= ac_next;
        s6_hmag_reg  <= s5_hmag_reg;
        s6_a_reg     <= s5_a_reg;
        s6_hn_reg    <= s5_hn_reg;
        s6_cn_reg    <= s5_cn_reg;
        s6_czero_reg <= s5_czero_reg;
        s6_azero_reg <= s5_azero_reg;

        sq_e_reg[0]    <= EE'(d_next) << (2 * FRAC_BITS);
        sq_root_reg[0] <= '0;
        sq_rem_reg[0]  <= '0;
        sq_side_reg[0] <= side_next;
    end

    // ---------------- root unit: one root bit per stage, restoring
    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        logic [TW-1:0]  rem_sh, trial;
        logic [SW-1:0]  root_next;
        logic [RMW-1:0] rem_next;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k], sq_e_reg[k][EE-1 -: 2]};
            trial  = TW'({sq_root_reg[k], 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = RMW'(rem_sh - trial);
                root_next = {sq_root_reg[k][SW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RMW'(rem_sh);
                root_next = {sq_root_reg[k][SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_e_reg[k+1]    <= sq_e_reg[k] << 2;
            sq_root_reg[k+1] <= root_next;
            sq_rem_reg[k+1]  <= rem_next;
            sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    // ---------------- root selection
    logic          n_valid_reg, n_hit_reg;
    logic [NW-1:0] n_num_reg;
    logic [AW-1:0] n_a_reg;
    logic [NW-1:0] num_next, m_val, s_val, sp_val;
    logic          hit_next, exact, hpos;
    rchd_side_t    sd;

    assign sd     = sq_side_reg[SW];
    assign exact  = (sq_rem_reg[SW] == '0);
    assign hpos   = !sd.hn && (sd.hmag != '0);
    assign m_val  = NW'(sd.hmag) << FRAC_BITS;
    assign s_val  = NW'(sq_root_reg[SW]);
    // ceiling root when the square root was not exact
    assign sp_val = s_val + NW'(!exact);

    always_comb
    begin
        num_next = '0;
        hit_next = 1'b0;
        if (sd.nohit)
        begin
            hit_next = 1'b0;
        end
        else if (!sd.cn && !hpos)
        begin
            // nearer root
            hit_next = 1'b1;
            if (m_val >= sp_val)
                num_next = m_val - sp_val;
        end
        else if (!hpos || sd.cn || sd.czero)
        begin
            // farther root
            hit_next = 1'b1;
            if (!hpos)
                num_next = m_val + s_val;
            else if (s_val >= m_val)
                num_next = s_val - m_val;
        end
    end

    // ---------------- saturation check, then divider
    logic                  dv_valid_reg [0:COORD_BITS];
    logic [QW-1:0]         dv_rem_reg   [0:COORD_BITS];
    logic [AW-1:0]         dv_a_reg     [0:COORD_BITS];
    logic [COORD_BITS-1:0] dv_q_reg     [0:COORD_BITS];
    logic                  dv_hit_reg   [0:COORD_BITS];
    logic                  dv_sat_reg   [0:COORD_BITS];
    logic                  sat_next;

    assign sat_next = n_hit_reg && (QW'(n_num_reg) >= (QW'(n_a_reg) << COORD_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg     <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            n_valid_reg     <= sq_valid_reg[SW];
            dv_valid_reg[0] <= n_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_num_reg     <= num_next;
        n_hit_reg     <= hit_next;
        n_a_reg       <= sd.a;
        dv_rem_reg[0] <= QW'(n_num_reg);
        dv_a_reg[0]   <= n_a_reg;
        dv_q_reg[0]   <= '0;
        dv_hit_reg[0] <= n_hit_reg;
        dv_sat_reg[0] <= sat_next;
    end

    for (genvar j = 0; j < COORD_BITS; j++)
    begin : g_div
        localparam int BP = COORD_BITS - 1 - j;
        logic [QW-1:0]         trial, rem_next;
        logic [COORD_BITS-1:0] q_next;
        logic                  ge;

        always_comb
        begin
            trial    = QW'(dv_a_reg[j]) << BP;
            ge       = (dv_rem_reg[j] >= trial);
            rem_next = ge ? dv_rem_reg[j] - trial : dv_rem_reg[j];
            q_next     = dv_q_reg[j];
            q_next[BP] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j+1] <= rem_next;
            dv_a_reg[j+1]   <= dv_a_reg[j];
            dv_q_reg[j+1]   <= q_next;
            dv_hit_reg[j+1] <= dv_hit_reg[j];
            dv_sat_reg[j+1] <= dv_sat_reg[j];
        end
    end

    // ---------------- output word
    logic         done_reg;
    rchd_result_t result_reg, result_next;

    always_comb
    begin
        result_next.hit       = dv_hit_reg[COORD_BITS];
        result_next.saturated = dv_hit_reg[COORD_BITS] & dv_sat_reg[COORD_BITS];
        if (!dv_hit_reg[COORD_BITS])
            result_next.distance = '0;
        else if (dv_sat_reg[COORD_BITS])
            result_next.distance = '1;
        else
            result_next.distance = dv_q_reg[COORD_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid_reg[COORD_BITS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result word missing at fixed latency");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> (result.distance == '0) && !result.saturated)
        else $error("miss word carries distance or flag");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |-> (result.distance == '1))
        else $error("saturated distance not at maximum");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[SW] |-> (sq_rem_reg[SW] <= {sq_root_reg[SW], 1'b0}))
        else $error("square root remainder out of bound");

endmodule
